### design/lgt_pkg.sv
// Shared types, constants and codes for the toroidal life generation block.
package lgt_pkg;

  localparam int ROW_W      = 64;
  localparam int IDX_W      = 6;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int MAX_ROWS_DEFAULT = 64;
  localparam int MAX_COLS_DEFAULT = 64;

  localparam logic [CFG_W-1:0] ROW_COUNT_RESET    = 7'd20;
  localparam logic [CFG_W-1:0] COLUMN_COUNT_RESET = 7'd60;
  localparam logic [CFG_W-1:0] MIN_SIZE           = 7'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'd1;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  localparam logic [3:0] BIRTH_COUNT  = 4'd3;
  localparam logic [3:0] SURVIVE_LOW  = 4'd2;
  localparam logic [3:0] SURVIVE_HIGH = 4'd3;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] row_index;
    logic [ROW_W-1:0] row_cells;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] out_row_index;
    logic [ROW_W-1:0] out_row_cells;
    logic             last_row;
  } out_item_t;

  typedef enum logic {
    OP_LOAD,
    OP_STEP
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] addr;
    logic [ROW_W-1:0] cells;
  } cmd_t;

  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] maxv);
    logic [CFG_W-1:0] r;
    r = v;
    if (v < MIN_SIZE) r = MIN_SIZE;
    else if (v > maxv) r = maxv;
    return r;
  endfunction

endpackage

### design/lgt_front.sv
// Front end: accepts items, decodes them into commands and queues them for the back end.
module lgt_front #(
  parameter int MAX_ROWS = lgt_pkg::MAX_ROWS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lgt_pkg::in_item_t in_item,
  output logic              cmd_valid,
  input  logic              cmd_pop,
  output lgt_pkg::cmd_t     cmd
);
  import lgt_pkg::*;

  localparam int DEPTH = 2;

  cmd_t        slots [DEPTH];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  cmd_t        dec;
  logic        push;
  logic        pop;

  always_comb begin
    dec.op    = (in_item.kind == KIND_STEP) ? OP_STEP : OP_LOAD;
    dec.addr  = in_item.row_index & IDX_W'(MAX_ROWS - 1);
    dec.cells = in_item.row_cells;
  end

  assign in_ready  = (fill != 2'(DEPTH));
  assign push      = in_valid && in_ready;
  assign cmd_valid = (fill != 2'd0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= dec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### design/lgt_back.sv
// Back end: grid memory, load writes and the in-place row-by-row generation sweep.
module lgt_back #(
  parameter int MAX_ROWS = lgt_pkg::MAX_ROWS_DEFAULT,
  parameter int MAX_COLS = lgt_pkg::MAX_COLS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  output logic                      cmd_pop,
  input  lgt_pkg::cmd_t             cmd,
  input  logic [lgt_pkg::CFG_W-1:0] row_count,
  input  logic [lgt_pkg::CFG_W-1:0] column_count,
  output logic                      out_valid,
  input  logic                      out_ready,
  output lgt_pkg::out_item_t        out_item
);
  import lgt_pkg::*;

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RW = $clog2(MAX_ROWS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PRIME,
    S_ROW
  } state_t;

  state_t           state;
  logic [ROW_W-1:0] grid [MAX_ROWS];
  logic [MAX_ROWS-1:0] written;
  logic [ROW_W-1:0] rd0_raw;
  logic [ROW_W-1:0] rd1_raw;
  logic             rd0_ok;
  logic             rd1_ok;
  logic [ROW_W-1:0] rd0;
  logic [ROW_W-1:0] rd1;
  logic [ROW_W-1:0] saved_first_row;
  logic [ROW_W-1:0] previous_old_row;
  logic [ROW_W-1:0] cur_row;
  logic [RW-1:0]    row;
  logic [CFG_W-1:0] nrows;
  logic [CFG_W-1:0] ncols;

  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [ROW_W-1:0] mem_wd;
  logic             mem_re;
  logic [AW-1:0]    mem_ra0;
  logic [AW-1:0]    mem_ra1;

  logic             advance;
  logic             at_last;
  logic [ROW_W-1:0] down_row;
  logic [ROW_W-1:0] new_row;

  function automatic logic [ROW_W-1:0] next_row(input logic [ROW_W-1:0] up,
                                                input logic [ROW_W-1:0] mid,
                                                input logic [ROW_W-1:0] dn,
                                                input logic [CFG_W-1:0] cols);
    logic [ROW_W-1:0] res;
    logic [IDX_W-1:0] lf;
    logic [IDX_W-1:0] rt;
    logic [3:0]       n;
    res = '0;
    for (int c = 0; c < ROW_W; c++) begin
      lf = (c == 0) ? IDX_W'(cols - 7'd1) : IDX_W'(c - 1);
      rt = (CFG_W'(c + 1) >= cols) ? '0 : IDX_W'(c + 1);
      n = 4'(up[lf]) + 4'(up[c]) + 4'(up[rt]) + 4'(mid[lf]) + 4'(mid[rt])
        + 4'(dn[lf]) + 4'(dn[c]) + 4'(dn[rt]);
      if (CFG_W'(c) < cols) begin
        if (mid[c]) res[c] = (n == SURVIVE_LOW) || (n == SURVIVE_HIGH);
        else        res[c] = (n == BIRTH_COUNT);
      end
    end
    return res;
  endfunction

  assign nrows = clamp_size(row_count, CFG_W'(MAX_ROWS));
  assign ncols = clamp_size(column_count, CFG_W'(MAX_COLS));

  assign rd0 = rd0_ok ? rd0_raw : '0;
  assign rd1 = rd1_ok ? rd1_raw : '0;

  assign advance  = !out_valid || out_ready;
  assign at_last  = (CFG_W'(row) + 7'd1 == nrows);
  assign down_row = at_last ? saved_first_row : rd0;
  assign new_row  = next_row(previous_old_row, cur_row, down_row, ncols);

  always_comb begin
    cmd_pop = 1'b0;
    mem_we  = 1'b0;
    mem_wa  = cmd.addr[AW-1:0];
    mem_wd  = cmd.cells;
    mem_re  = 1'b0;
    mem_ra0 = '0;
    mem_ra1 = AW'(nrows - 7'd1);
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.op == OP_LOAD) mem_we = 1'b1;
          else                   mem_re = 1'b1;
        end
      end
      S_PRIME: begin
        mem_re  = 1'b1;
        mem_ra0 = AW'(1);
      end
      S_ROW: begin
        if (advance) begin
          mem_we  = 1'b1;
          mem_wa  = row[AW-1:0];
          mem_wd  = new_row;
          mem_re  = 1'b1;
          mem_ra0 = AW'(row + RW'(2));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) grid[mem_wa] <= mem_wd;
    if (mem_re) begin
      rd0_raw <= grid[mem_ra0];
      rd1_raw <= grid[mem_ra1];
      rd0_ok  <= written[mem_ra0];
      rd1_ok  <= written[mem_ra1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) written <= '0;
    else if (mem_we) written[mem_wa] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      row       <= '0;
    end else begin
      // the sweep refills the output register itself
      if ((state != S_ROW) && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid && cmd.op == OP_STEP) state <= S_PRIME;
        end
        S_PRIME: begin
          saved_first_row  <= rd0;
          cur_row          <= rd0;
          previous_old_row <= rd1;
          row              <= '0;
          state            <= S_ROW;
        end
        S_ROW: begin
          if (advance) begin
            out_valid              <= 1'b1;
            out_item.out_row_index <= IDX_W'(row);
            out_item.out_row_cells <= new_row;
            out_item.last_row      <= at_last;
            previous_old_row       <= cur_row;
            cur_row                <= down_row;
            row                    <= row + RW'(1);
            if (at_last) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### design/life_generation_torus.sv
// Top level of the toroidal life generation block: configuration registers, front and back.
//
// Items arrive on in_valid/in_ready/in_item. A load item (kind 0) writes row_cells to
// row_index of the grid and gives no result; it is written as it leaves the queue. A step
// item (kind 1) computes the next B3/S23 generation on the torus of row_count by
// column_count cells and sends one result per row in use, row 0 first, on
// out_valid/out_ready/out_item, with last_row set on the final row.
// The row count in use is row_count held to 3..MAX_ROWS. A step reads the first and last
// rows as it leaves the queue, reads row 1 in S_PRIME, then in S_ROW gives one row per
// cycle while the receiver takes results, in the single sweep over the grid memory that
// reads two rows ahead while writing the current one back. Results are registered in S_ROW.
// A two-item queue sits between front and back, so input is still taken while a
// result waits. When out_ready is low while a result is held, the sweep holds its row.
// The user writes configuration (cfg_we, cfg_index, cfg_data) only while the block is
// idle; the block itself does not enforce it. Reset clears the grid to all dead, sets
// row_count 20 and column_count 60, and empties the queue and the output register.
module life_generation_torus #(
  parameter int MAX_ROWS = lgt_pkg::MAX_ROWS_DEFAULT,
  parameter int MAX_COLS = lgt_pkg::MAX_COLS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lgt_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lgt_pkg::out_item_t            out_item,
  input  logic                          cfg_we,
  input  logic [lgt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lgt_pkg::CFG_W-1:0]     cfg_data
);
  import lgt_pkg::*;

  logic [CFG_W-1:0] row_count;
  logic [CFG_W-1:0] column_count;
  logic             cmd_valid;
  logic             cmd_pop;
  cmd_t             cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= ROW_COUNT_RESET;
      column_count <= COLUMN_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROW_COUNT:    row_count    <= cfg_data;
        CFG_COLUMN_COUNT: column_count <= cfg_data;
        default: ;
      endcase
    end
  end

  lgt_front #(
    .MAX_ROWS(MAX_ROWS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .cmd_valid(cmd_valid),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd)
  );

  lgt_back #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_pop     (cmd_pop),
    .cmd         (cmd),
    .row_count   (row_count),
    .column_count(column_count),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item)
  );

endmodule
